### hdl/jhsp_pkg.sv
// Shared constants, record kinds, phase encoding and stage types for the header parser.
`default_nettype none

package jhsp_pkg;

  // Largest number of frame or scan components that are reported.
  localparam int unsigned MAX_COMPONENTS = 4;

  // Marker bytes.
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_DQT    = 8'hDB;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_SOS    = 8'hDA;

  // Largest Huffman symbol total that is not flagged.
  localparam logic [11:0] HUFF_TOTAL_LIMIT = 12'd256;

  // Record kinds.
  localparam logic [3:0] KIND_QUANT      = 4'd0;
  localparam logic [3:0] KIND_PRECISION  = 4'd1;
  localparam logic [3:0] KIND_HEIGHT     = 4'd2;
  localparam logic [3:0] KIND_WIDTH      = 4'd3;
  localparam logic [3:0] KIND_COMP_COUNT = 4'd4;
  localparam logic [3:0] KIND_COMPONENT  = 4'd5;
  localparam logic [3:0] KIND_HUFF_COUNT = 4'd6;
  localparam logic [3:0] KIND_HUFF_VALUE = 4'd7;
  localparam logic [3:0] KIND_HUFF_TOTAL = 4'd8;
  localparam logic [3:0] KIND_SCAN_COUNT = 4'd9;
  localparam logic [3:0] KIND_SCAN_COMP  = 4'd10;
  localparam logic [3:0] KIND_HDR_DONE   = 4'd11;
  localparam logic [3:0] KIND_END_IMAGE  = 4'd12;
  localparam logic [3:0] KIND_SKIPPED    = 4'd13;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_SCAN,
    PH_MARK,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  // One result record.
  typedef struct packed {
    logic [3:0]  record_kind;
    logic        table_class;
    logic [3:0]  table_select;
    logic [7:0]  entry_index;
    logic [15:0] field_value;
    logic [3:0]  sampling_h;
    logic [3:0]  sampling_v;
    logic [3:0]  dc_table;
    logic [3:0]  ac_table;
    logic        error_flag;
  } record_t;

  // Input register contents handed to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  // Record produced by the parser for the output register.
  typedef struct packed {
    logic    valid;
    record_t rec;
  } rec_stage_t;

endpackage

`default_nettype wire

### hdl/jhsp_ifs.sv
// Valid/ready channel interfaces for the byte stream and the record stream.
`default_nettype none

interface jhsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

interface jhsp_rec_if;
  logic             valid;
  logic             ready;
  jhsp_pkg::record_t rec;

  modport source(output valid, output rec, input ready);
  modport sink(input valid, input rec, output ready);
endinterface

`default_nettype wire

### hdl/jhsp_in_stage.sv
// Input register that holds one accepted stream byte until the parser takes it.
`default_nettype none

module jhsp_in_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  jhsp_byte_if.sink                  stream,
  input  wire logic                  take,
  output jhsp_pkg::byte_stage_t      held
);

  logic       full;
  logic [7:0] data;

  // The register can load when it is empty or its byte leaves this cycle.
  assign stream.ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      data <= stream.stream_byte;
    end
  end

  assign held.valid = full;
  assign held.data  = data;

endmodule

`default_nettype wire

### hdl/jhsp_parser.sv
// Marker and segment state machine that turns one byte into at most one record.
`default_nettype none

module jhsp_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire jhsp_pkg::byte_stage_t held,
  input  wire logic                  take,
  output jhsp_pkg::rec_stage_t       result
);

  jhsp_pkg::phase_t phase, phase_next;

  logic [7:0]  marker, marker_next;
  logic [15:0] plen, plen_next;
  logic [15:0] pos, pos_next;
  logic [7:0]  item_count, item_count_next;
  logic [11:0] sym_total, sym_total_next;
  logic        held_cls, held_cls_next;
  logic [3:0]  held_sel, held_sel_next;
  logic [7:0]  held_hi, held_hi_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_samp, held_samp_next;
  logic [1:0]  sub, sub_next;
  logic [7:0]  slot, slot_next;

  logic [7:0]  b;
  logic        step;
  logic [15:0] len_word;
  logic [15:0] plen_new;
  logic        last;
  logic [15:0] pos_m1;
  logic [15:0] pos_m17;
  logic [11:0] sym_sum;
  logic [7:0]  slot_inc;
  logic        in_range;
  logic        known;
  logic        has_rec;
  jhsp_pkg::record_t rec;

  assign b    = held.data;
  assign step = held.valid && take;

  // Shared arithmetic on the current byte and position.
  assign len_word = {held_hi, b};
  assign plen_new = (len_word >= 16'd2) ? (len_word - 16'd2) : 16'd0;
  assign last     = ({1'b0, pos} + 17'd1) >= {1'b0, plen};
  assign pos_m1   = pos - 16'd1;
  assign pos_m17  = pos - 16'd17;
  assign sym_sum  = sym_total + {4'd0, b};
  assign slot_inc = (slot == 8'hFF) ? slot : (slot + 8'd1);
  assign in_range = (slot < item_count) &&
                    ({24'd0, slot} < 32'(jhsp_pkg::MAX_COMPONENTS));
  assign known    = (marker == jhsp_pkg::MARK_DQT) || (marker == jhsp_pkg::MARK_SOF0) ||
                    (marker == jhsp_pkg::MARK_DHT) || (marker == jhsp_pkg::MARK_SOS);

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        jhsp_pkg::PH_SCAN: begin
          if (b == jhsp_pkg::MARK_PREFIX) phase_next = jhsp_pkg::PH_MARK;
        end
        jhsp_pkg::PH_MARK: begin
          priority if (b == jhsp_pkg::MARK_PREFIX) phase_next = jhsp_pkg::PH_MARK;
          else if (b == jhsp_pkg::MARK_SOI)        phase_next = jhsp_pkg::PH_SCAN;
          else if (b == jhsp_pkg::MARK_EOI)        phase_next = jhsp_pkg::PH_DONE;
          else                                     phase_next = jhsp_pkg::PH_LEN_HI;
        end
        jhsp_pkg::PH_LEN_HI: phase_next = jhsp_pkg::PH_LEN_LO;
        jhsp_pkg::PH_LEN_LO: begin
          if (plen_new == 16'd0) begin
            phase_next = (marker == jhsp_pkg::MARK_SOS) ? jhsp_pkg::PH_DONE
                                                        : jhsp_pkg::PH_SCAN;
          end else begin
            phase_next = jhsp_pkg::PH_PAYLOAD;
          end
        end
        jhsp_pkg::PH_PAYLOAD: begin
          if (last) begin
            phase_next = (marker == jhsp_pkg::MARK_SOS) ? jhsp_pkg::PH_DONE
                                                        : jhsp_pkg::PH_SCAN;
          end
        end
        jhsp_pkg::PH_DONE: phase_next = jhsp_pkg::PH_DONE;
        default:           phase_next = jhsp_pkg::PH_SCAN;
      endcase
    end
  end

  // Segment bookkeeping and held fields.
  always_comb begin
    marker_next     = marker;
    plen_next       = plen;
    pos_next        = pos;
    item_count_next = item_count;
    sym_total_next  = sym_total;
    held_cls_next   = held_cls;
    held_sel_next   = held_sel;
    held_hi_next    = held_hi;
    held_id_next    = held_id;
    held_samp_next  = held_samp;
    sub_next        = sub;
    slot_next       = slot;
    if (step) begin
      unique case (phase)
        jhsp_pkg::PH_MARK: begin
          if (b != jhsp_pkg::MARK_PREFIX && b != jhsp_pkg::MARK_SOI &&
              b != jhsp_pkg::MARK_EOI) begin
            marker_next = b;
          end
        end
        jhsp_pkg::PH_LEN_HI: held_hi_next = b;
        jhsp_pkg::PH_LEN_LO: begin
          plen_next       = plen_new;
          pos_next        = 16'd0;
          item_count_next = 8'd0;
          sym_total_next  = 12'd0;
          held_cls_next   = 1'b0;
          held_sel_next   = 4'd0;
          sub_next        = 2'd0;
          slot_next       = 8'd0;
        end
        jhsp_pkg::PH_PAYLOAD: begin
          pos_next = pos + 16'd1;
          priority if (marker == jhsp_pkg::MARK_DQT) begin
            if (pos == 16'd0) held_sel_next = b[3:0];
          end else if (marker == jhsp_pkg::MARK_SOF0) begin
            // Components are three bytes each from payload position six on.
            if (pos == 16'd1 || pos == 16'd3) held_hi_next = b;
            if (pos == 16'd5) item_count_next = b;
            if (pos >= 16'd6) begin
              if (in_range && sub == 2'd0) held_id_next = b;
              if (in_range && sub == 2'd1) held_samp_next = b;
              if (sub == 2'd2) begin
                sub_next  = 2'd0;
                slot_next = slot_inc;
              end else begin
                sub_next = sub + 2'd1;
              end
            end
          end else if (marker == jhsp_pkg::MARK_DHT) begin
            if (pos == 16'd0) begin
              held_cls_next = b[4];
              held_sel_next = b[3:0];
            end else if (pos <= 16'd16) begin
              sym_total_next = sym_sum;
            end
          end else if (marker == jhsp_pkg::MARK_SOS) begin
            // Scan components are two bytes each after the count.
            if (pos == 16'd0) begin
              item_count_next = b;
            end else begin
              if (in_range && sub == 2'd0) held_id_next = b;
              if (sub == 2'd1) begin
                sub_next  = 2'd0;
                slot_next = slot_inc;
              end else begin
                sub_next = 2'd1;
              end
            end
          end else begin
            marker_next = marker;
          end
        end
        default: begin
          marker_next = marker;
        end
      endcase
    end
  end

  // Record for the current byte.
  always_comb begin
    has_rec = 1'b0;
    rec     = '0;
    unique case (phase)
      jhsp_pkg::PH_MARK: begin
        if (b == jhsp_pkg::MARK_EOI) begin
          has_rec          = 1'b1;
          rec.record_kind  = jhsp_pkg::KIND_END_IMAGE;
          rec.field_value  = {8'd0, jhsp_pkg::MARK_EOI};
        end
      end
      jhsp_pkg::PH_LEN_LO: begin
        if (!known) begin
          has_rec          = 1'b1;
          rec.record_kind  = jhsp_pkg::KIND_SKIPPED;
          rec.field_value  = {8'd0, marker};
        end
        if (plen_new == 16'd0 && marker == jhsp_pkg::MARK_SOS) begin
          has_rec          = 1'b1;
          rec              = '0;
          rec.record_kind  = jhsp_pkg::KIND_HDR_DONE;
          rec.field_value  = {8'd0, jhsp_pkg::MARK_SOS};
        end
      end
      jhsp_pkg::PH_PAYLOAD: begin
        priority if (marker == jhsp_pkg::MARK_DQT) begin
          if (pos != 16'd0 && pos <= 16'd64) begin
            has_rec          = 1'b1;
            rec.record_kind  = jhsp_pkg::KIND_QUANT;
            rec.table_select = held_sel;
            rec.entry_index  = pos_m1[7:0];
            rec.field_value  = {8'd0, b};
          end
        end else if (marker == jhsp_pkg::MARK_SOF0) begin
          priority if (pos == 16'd0) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_PRECISION;
            rec.field_value = {8'd0, b};
          end else if (pos == 16'd2) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_HEIGHT;
            rec.field_value = len_word;
          end else if (pos == 16'd4) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_WIDTH;
            rec.field_value = len_word;
          end else if (pos == 16'd5) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_COMP_COUNT;
            rec.field_value = {8'd0, b};
          end else if (pos >= 16'd6 && in_range && sub == 2'd2) begin
            has_rec          = 1'b1;
            rec.record_kind  = jhsp_pkg::KIND_COMPONENT;
            rec.table_select = b[3:0];
            rec.entry_index  = slot;
            rec.field_value  = {8'd0, held_id};
            rec.sampling_h   = held_samp[7:4];
            rec.sampling_v   = held_samp[3:0];
          end else begin
            has_rec = 1'b0;
          end
        end else if (marker == jhsp_pkg::MARK_DHT) begin
          rec.table_class  = held_cls;
          rec.table_select = held_sel;
          priority if (pos == 16'd0) begin
            rec = '0;
          end else if (pos < 16'd16) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_HUFF_COUNT;
            rec.entry_index = pos_m1[7:0];
            rec.field_value = {8'd0, b};
          end else if (pos == 16'd16) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_HUFF_TOTAL;
            rec.entry_index = 8'd15;
            rec.field_value = {4'd0, sym_sum};
            rec.error_flag  = sym_sum > jhsp_pkg::HUFF_TOTAL_LIMIT;
          end else if (pos_m17 < {4'd0, sym_total} && pos_m17 < 16'd256) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_HUFF_VALUE;
            rec.entry_index = pos_m17[7:0];
            rec.field_value = {8'd0, b};
          end else begin
            rec = '0;
          end
        end else if (marker == jhsp_pkg::MARK_SOS) begin
          priority if (pos == 16'd0) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_SCAN_COUNT;
            rec.field_value = {8'd0, b};
          end else if (in_range && sub == 2'd1) begin
            has_rec         = 1'b1;
            rec.record_kind = jhsp_pkg::KIND_SCAN_COMP;
            rec.entry_index = slot;
            rec.field_value = {8'd0, held_id};
            rec.dc_table    = b[7:4];
            rec.ac_table    = b[3:0];
          end else begin
            has_rec = 1'b0;
          end
        end else begin
          has_rec = 1'b0;
        end
        // The last scan header byte reports completion instead.
        if (last && marker == jhsp_pkg::MARK_SOS) begin
          has_rec         = 1'b1;
          rec             = '0;
          rec.record_kind = jhsp_pkg::KIND_HDR_DONE;
          rec.field_value = {8'd0, jhsp_pkg::MARK_SOS};
        end
      end
      default: begin
        has_rec = 1'b0;
      end
    endcase
  end

  assign result.valid = step && has_rec;
  assign result.rec   = rec;

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jhsp_pkg::PH_SCAN;
    end else begin
      phase <= phase_next;
    end
  end

  // Segment registers; each is loaded before it is read.
  always_ff @(posedge clk) begin
    marker     <= marker_next;
    plen       <= plen_next;
    pos        <= pos_next;
    item_count <= item_count_next;
    sym_total  <= sym_total_next;
    held_cls   <= held_cls_next;
    held_sel   <= held_sel_next;
    held_hi    <= held_hi_next;
    held_id    <= held_id_next;
    held_samp  <= held_samp_next;
    sub        <= sub_next;
    slot       <= slot_next;
  end

endmodule

`default_nettype wire

### hdl/jhsp_out_stage.sv
// Output register that holds one record until the downstream side takes it.
`default_nettype none

module jhsp_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire jhsp_pkg::rec_stage_t  result,
  jhsp_rec_if.source                 records,
  output logic                       free
);

  logic              full;
  jhsp_pkg::record_t rec;

  // A new record may land when the register is empty or being emptied.
  assign free = !full || records.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (result.valid) begin
      full <= 1'b1;
    end else if (records.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      rec <= result.rec;
    end
  end

  assign records.valid = full;
  assign records.rec   = rec;

endmodule

`default_nettype wire

### hdl/jpeg_header_segment_parser.sv
// Top level of the streaming JPEG header parser: input register, parser, output register.
//
//   Channel   Modport  Carries               Moves per request
//   stream    sink     stream_byte (8 bits)  one file byte
//   records   source   record_t fields       one parsed record
//
// One byte is taken per cycle; with records ready held high the block never stalls.
// A record passes through the input register and then the output register before it is
// presented; the parse state machine updates once for each byte that the parser takes.
// Reset (rst, synchronous) empties both registers and returns to marker scanning.
// A stalled record register holds the parser, which then holds the input register.
`default_nettype none

module jpeg_header_segment_parser (
  input  wire logic  clk,
  input  wire logic  rst,
  jhsp_byte_if.sink  stream,
  jhsp_rec_if.source records
);

  jhsp_pkg::byte_stage_t held;
  jhsp_pkg::rec_stage_t  result;
  logic                  free;
  logic                  take;

  // The parser consumes the held byte whenever its record can be stored.
  assign take = held.valid && free;

  jhsp_in_stage u_in (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .take   (take),
    .held   (held)
  );

  jhsp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .held   (held),
    .take   (take),
    .result (result)
  );

  jhsp_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .result  (result),
    .records (records),
    .free    (free)
  );

`ifndef ASSERT_OFF
  // A record is only produced for a byte that is being consumed.
  a_rec_needs_take: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> take)
    else $error("record produced without a consumed byte");

  // A produced record is presented on the next cycle.
  a_rec_presented: assert property (@(posedge clk) disable iff (rst)
    result.valid |=> records.valid)
    else $error("produced record was lost");

  // An accepted byte is held in the input register on the next cycle.
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.ready |=> held.valid)
    else $error("accepted byte was lost");

  // A stalled record register must not be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    records.valid && !records.ready |-> !result.valid)
    else $error("pending record overwritten");
`endif

endmodule

`default_nettype wire

### sim/jhsp_record_monitor.sv
// Monitor that predicts parser records from accepted bytes and compares them with the output.
`timescale 1ns / 100ps

module jhsp_record_monitor (
  input  logic clk,
  input  logic rst,
  jhsp_byte_if byte_mon,
  jhsp_rec_if  rec_mon,
  output int   failures,
  output int   outstanding
);

  // Parser state as the block should hold it.
  jhsp_pkg::phase_t cur_phase;
  logic [7:0]  seg_marker;
  logic [15:0] seg_len;
  logic [15:0] pos;
  logic [7:0]  n_items;
  logic [11:0] sym_total;
  logic [4:0]  held_sel;
  logic [7:0]  high_byte;
  logic [7:0]  comp_id;
  logic [7:0]  samp_byte;

  // Records predicted but not yet seen on the output.
  jhsp_pkg::record_t expected_records[$];

  function automatic jhsp_pkg::record_t build_rec(logic [3:0] kind, logic cls,
                                                  logic [3:0] sel, logic [7:0] idx,
                                                  logic [15:0] val);
    jhsp_pkg::record_t r;
    r = '0;
    r.record_kind  = kind;
    r.table_class  = cls;
    r.table_select = sel;
    r.entry_index  = idx;
    r.field_value  = val;
    return r;
  endfunction

  // Works out the record, if any, that one accepted byte causes.
  function automatic void advance_parser(input logic [7:0] b);
    jhsp_pkg::record_t r;
    bit          hit;
    int unsigned plen;
    int unsigned p;
    int unsigned q;
    int unsigned k;
    r = '0;
    hit = 1'b0;
    plen = (seg_len >= 16'd2) ? seg_len - 16'd2 : 0;
    case (cur_phase)
      jhsp_pkg::PH_SCAN: begin
        if (b == jhsp_pkg::MARK_PREFIX) cur_phase = jhsp_pkg::PH_MARK;
      end
      jhsp_pkg::PH_MARK: begin
        if (b == jhsp_pkg::MARK_SOI) begin
          cur_phase = jhsp_pkg::PH_SCAN;
        end else if (b == jhsp_pkg::MARK_EOI) begin
          r = build_rec(jhsp_pkg::KIND_END_IMAGE, 1'b0, 4'd0, 8'd0,
                        {8'd0, jhsp_pkg::MARK_EOI});
          hit = 1'b1;
          cur_phase = jhsp_pkg::PH_DONE;
        end else if (b != jhsp_pkg::MARK_PREFIX) begin
          seg_marker = b;
          cur_phase = jhsp_pkg::PH_LEN_HI;
        end
      end
      jhsp_pkg::PH_LEN_HI: begin
        high_byte = b;
        cur_phase = jhsp_pkg::PH_LEN_LO;
      end
      jhsp_pkg::PH_LEN_LO: begin
        seg_len = {high_byte, b};
        plen = (seg_len >= 16'd2) ? seg_len - 16'd2 : 0;
        pos = 16'd0;
        n_items = 8'd0;
        sym_total = 12'd0;
        held_sel = 5'd0;
        if (!(seg_marker inside {jhsp_pkg::MARK_DQT, jhsp_pkg::MARK_SOF0,
                                 jhsp_pkg::MARK_DHT, jhsp_pkg::MARK_SOS})) begin
          r = build_rec(jhsp_pkg::KIND_SKIPPED, 1'b0, 4'd0, 8'd0, {8'd0, seg_marker});
          hit = 1'b1;
        end
        if (plen == 0) begin
          if (seg_marker == jhsp_pkg::MARK_SOS) begin
            r = build_rec(jhsp_pkg::KIND_HDR_DONE, 1'b0, 4'd0, 8'd0,
                          {8'd0, jhsp_pkg::MARK_SOS});
            hit = 1'b1;
            cur_phase = jhsp_pkg::PH_DONE;
          end else begin
            cur_phase = jhsp_pkg::PH_SCAN;
          end
        end else begin
          cur_phase = jhsp_pkg::PH_PAYLOAD;
        end
      end
      jhsp_pkg::PH_PAYLOAD: begin
        p = pos;
        case (seg_marker)
          // Quantization table: index byte, then 64 entries of the first table.
          jhsp_pkg::MARK_DQT: begin
            if (p == 0) begin
              held_sel = {1'b0, b[3:0]};
            end else if (p <= 64) begin
              r = build_rec(jhsp_pkg::KIND_QUANT, 1'b0, held_sel[3:0], 8'(p - 1),
                            {8'd0, b});
              hit = 1'b1;
            end
          end
          // Frame header: precision, size, count, then three bytes per component.
          jhsp_pkg::MARK_SOF0: begin
            if (p == 0) begin
              r = build_rec(jhsp_pkg::KIND_PRECISION, 1'b0, 4'd0, 8'd0, {8'd0, b});
              hit = 1'b1;
            end else if (p == 1 || p == 3) begin
              high_byte = b;
            end else if (p == 2) begin
              r = build_rec(jhsp_pkg::KIND_HEIGHT, 1'b0, 4'd0, 8'd0, {high_byte, b});
              hit = 1'b1;
            end else if (p == 4) begin
              r = build_rec(jhsp_pkg::KIND_WIDTH, 1'b0, 4'd0, 8'd0, {high_byte, b});
              hit = 1'b1;
            end else if (p == 5) begin
              n_items = b;
              r = build_rec(jhsp_pkg::KIND_COMP_COUNT, 1'b0, 4'd0, 8'd0, {8'd0, b});
              hit = 1'b1;
            end else begin
              q = p - 6;
              k = q / 3;
              if (k < n_items && k < jhsp_pkg::MAX_COMPONENTS) begin
                if (q % 3 == 0) begin
                  comp_id = b;
                end else if (q % 3 == 1) begin
                  samp_byte = b;
                end else begin
                  r = build_rec(jhsp_pkg::KIND_COMPONENT, 1'b0, b[3:0], 8'(k),
                                {8'd0, comp_id});
                  r.sampling_h = samp_byte[7:4];
                  r.sampling_v = samp_byte[3:0];
                  hit = 1'b1;
                end
              end
            end
          end
          // Huffman table: class and index, sixteen counts, then the values.
          jhsp_pkg::MARK_DHT: begin
            if (p == 0) begin
              held_sel = {b[4], b[3:0]};
            end else if (p < 16) begin
              sym_total = sym_total + 12'(b);
              r = build_rec(jhsp_pkg::KIND_HUFF_COUNT, held_sel[4], held_sel[3:0],
                            8'(p - 1), {8'd0, b});
              hit = 1'b1;
            end else if (p == 16) begin
              sym_total = sym_total + 12'(b);
              r = build_rec(jhsp_pkg::KIND_HUFF_TOTAL, held_sel[4], held_sel[3:0], 8'd15,
                            {4'd0, sym_total});
              r.error_flag = (sym_total > jhsp_pkg::HUFF_TOTAL_LIMIT);
              hit = 1'b1;
            end else begin
              q = p - 17;
              if (q < sym_total && q < 256) begin
                r = build_rec(jhsp_pkg::KIND_HUFF_VALUE, held_sel[4], held_sel[3:0],
                              8'(q), {8'd0, b});
                hit = 1'b1;
              end
            end
          end
          // Scan header: count, then id and table byte per component.
          jhsp_pkg::MARK_SOS: begin
            if (p == 0) begin
              n_items = b;
              r = build_rec(jhsp_pkg::KIND_SCAN_COUNT, 1'b0, 4'd0, 8'd0, {8'd0, b});
              hit = 1'b1;
            end else begin
              q = p - 1;
              k = q / 2;
              if (k < n_items && k < jhsp_pkg::MAX_COMPONENTS) begin
                if (q[0] == 1'b0) begin
                  comp_id = b;
                end else begin
                  r = build_rec(jhsp_pkg::KIND_SCAN_COMP, 1'b0, 4'd0, 8'(k),
                                {8'd0, comp_id});
                  r.dc_table = b[7:4];
                  r.ac_table = b[3:0];
                  hit = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
        pos = pos + 16'd1;
        // The last payload byte closes the segment; for a scan it ends the header.
        if (p + 1 >= plen) begin
          if (seg_marker == jhsp_pkg::MARK_SOS) begin
            r = build_rec(jhsp_pkg::KIND_HDR_DONE, 1'b0, 4'd0, 8'd0,
                          {8'd0, jhsp_pkg::MARK_SOS});
            hit = 1'b1;
            cur_phase = jhsp_pkg::PH_DONE;
          end else begin
            cur_phase = jhsp_pkg::PH_SCAN;
          end
        end
      end
      default: ;
    endcase
    if (hit) expected_records.push_back(r);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function automatic void compare_record(jhsp_pkg::record_t want, jhsp_pkg::record_t got);
    check_field("record_kind", want.record_kind, got.record_kind);
    check_field("table_class", want.table_class, got.table_class);
    check_field("table_select", want.table_select, got.table_select);
    check_field("entry_index", want.entry_index, got.entry_index);
    check_field("field_value", want.field_value, got.field_value);
    check_field("sampling_h", want.sampling_h, got.sampling_h);
    check_field("sampling_v", want.sampling_v, got.sampling_v);
    check_field("dc_table", want.dc_table, got.dc_table);
    check_field("ac_table", want.ac_table, got.ac_table);
    check_field("error_flag", want.error_flag, got.error_flag);
  endfunction

  // Predict on each accepted byte, compare on each accepted record.
  always @(posedge clk) begin
    if (rst) begin
      cur_phase = jhsp_pkg::PH_SCAN;
      seg_marker = 8'd0;
      seg_len = 16'd0;
      pos = 16'd0;
      n_items = 8'd0;
      sym_total = 12'd0;
      held_sel = 5'd0;
      high_byte = 8'd0;
      comp_id = 8'd0;
      samp_byte = 8'd0;
      expected_records.delete();
      failures = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) advance_parser(byte_mon.stream_byte);
      if (rec_mon.valid && rec_mon.ready) begin
        if (expected_records.size() == 0) begin
          $error("record_kind: expected none, got %0d", rec_mon.rec.record_kind);
          failures++;
        end else begin
          compare_record(expected_records.pop_front(), rec_mon.rec);
        end
      end
    end
    outstanding = expected_records.size();
  end

endmodule

### sim/tb_jpeg_header_segment_parser.sv
// Testbench top for the JPEG header parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_jpeg_header_segment_parser;

  typedef logic [7:0] byte_q_t[$];

  // Segments that the parser skips.
  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] MARK_COM  = 8'hFE;
  localparam int         ITEM_GOAL = 1060;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   outstanding;
  int   bytes_sent = 0;
  int   burst_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;
  byte_q_t no_bytes;

  jhsp_byte_if stream_ch ();
  jhsp_rec_if  rec_ch ();

  jpeg_header_segment_parser dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .records (rec_ch)
  );

  jhsp_record_monitor rec_mon_i (
    .clk         (clk),
    .rst         (rst),
    .byte_mon    (stream_ch),
    .rec_mon     (rec_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Record receiver stalls on a 16-bit pattern that is replaced now and then.
  always @(negedge clk) begin
    if (pattern_age == 0) begin
      pattern_age <= $urandom_range(50, 400);
      stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      pattern_age <= pattern_age - 1;
    end
    rec_ch.ready <= stall_pattern[pattern_age[3:0]];
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("tb_jpeg_header_segment_parser: done, errors");
    $finish;
  end

  // Sends one byte request, with random gaps between bursts.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        stream_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    stream_ch.valid = 1'b1;
    stream_ch.stream_byte = b;
    do @(posedge clk); while (!stream_ch.ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic put_marker(input logic [7:0] code);
    repeat ($urandom_range(1, 3)) put_byte(jhsp_pkg::MARK_PREFIX);
    put_byte(code);
  endtask

  // Marker, length and payload; with no length given, an empty payload gets 0, 1 or 2.
  task automatic send_segment(input logic [7:0] code, input byte_q_t pay, input int len = -1);
    logic [15:0] seg_len;
    if (len >= 0) seg_len = 16'(len);
    else if (pay.size() == 0) seg_len = 16'($urandom_range(0, 2));
    else seg_len = 16'(pay.size() + 2);
    put_marker(code);
    put_byte(seg_len[15:8]);
    put_byte(seg_len[7:0]);
    foreach (pay[i]) put_byte(pay[i]);
  endtask

  // Holds the sender until every predicted record has come out.
  task automatic drain_records();
    stream_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  function automatic byte_q_t cut_to(byte_q_t pay, int n);
    while (pay.size() > n) void'(pay.pop_back());
    return pay;
  endfunction

  function automatic logic [7:0] pick_unknown();
    logic [7:0] code;
    do code = 8'($urandom_range(0, 254));
    while (code inside {jhsp_pkg::MARK_SOI, jhsp_pkg::MARK_EOI, jhsp_pkg::MARK_SOS,
                        jhsp_pkg::MARK_DQT, jhsp_pkg::MARK_SOF0, jhsp_pkg::MARK_DHT});
    return code;
  endfunction

  function automatic byte_q_t frame_payload(int n_comp, int n_sent);
    byte_q_t pay;
    pay = random_bytes(6 + 3 * n_sent);
    pay[5] = 8'(n_comp);
    return pay;
  endfunction

  // Index byte, counts from lo..hi, the values they announce (at most 256), extra bytes.
  function automatic byte_q_t huffman_payload(int lo, int hi, int extra);
    byte_q_t pay;
    int total;
    int c;
    total = 0;
    pay.push_back(8'($urandom_range(0, 255)));
    repeat (16) begin
      c = $urandom_range(lo, hi);
      pay.push_back(8'(c));
      total += c;
    end
    repeat ((total > 256 ? 256 : total) + extra) pay.push_back(8'($urandom_range(0, 255)));
    return pay;
  endfunction

  function automatic byte_q_t scan_payload(int n_comp, int n_sent);
    byte_q_t pay;
    pay = random_bytes(1 + 2 * n_sent);
    pay[0] = 8'(n_comp);
    return pay;
  endfunction

  initial begin
    byte_q_t    pay;
    logic [7:0] code;
    int         n;
    int         seg_no;
    int         guard;
    stream_ch.valid = 1'b0;
    stream_ch.stream_byte = 8'd0;
    rec_ch.ready = 1'b0;
    seg_no = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Stray bytes and a start-of-image marker outside any segment.
    put_byte(8'h00);
    put_byte(8'hFE);
    put_marker(jhsp_pkg::MARK_SOI);
    put_byte(8'h7F);

    // Skipped segments, among them empty and short lengths and a long one.
    send_segment(MARK_APP0, random_bytes(14));
    send_segment(MARK_COM, no_bytes, 0);
    send_segment(pick_unknown(), no_bytes, 1);
    send_segment(pick_unknown(), no_bytes, 2);
    send_segment(MARK_APP0, random_bytes(260));

    // Quantization tables: full with extreme entries, truncated, and one with extra bytes.
    pay = random_bytes(65);
    pay[1] = 8'h00;
    pay[64] = 8'hFF;
    send_segment(jhsp_pkg::MARK_DQT, pay);
    send_segment(jhsp_pkg::MARK_DQT, random_bytes(10));
    send_segment(jhsp_pkg::MARK_DQT, random_bytes(80));

    // Frame headers: largest size, extra components, truncated, zero count.
    pay = frame_payload(4, 4);
    for (int i = 1; i <= 4; i++) pay[i] = 8'hFF;
    send_segment(jhsp_pkg::MARK_SOF0, pay);
    pay = frame_payload(6, 6);
    for (int i = 1; i <= 4; i++) pay[i] = 8'h00;
    send_segment(jhsp_pkg::MARK_SOF0, pay);
    send_segment(jhsp_pkg::MARK_SOF0, cut_to(frame_payload(2, 2), 8));
    send_segment(jhsp_pkg::MARK_SOF0, frame_payload(0, 2));

    // Huffman tables: total at the flag limit cut short, largest total, and a short one.
    send_segment(jhsp_pkg::MARK_DHT, cut_to(huffman_payload(16, 16, 0), 24));
    send_segment(jhsp_pkg::MARK_DHT, huffman_payload(255, 255, 2));
    send_segment(jhsp_pkg::MARK_DHT, huffman_payload(0, 2, 3));
    drain_records();

    // Random segments until the byte goal is reached.
    while (bytes_sent < ITEM_GOAL) begin
      seg_no++;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          code = jhsp_pkg::MARK_DQT;
          pay = random_bytes(($urandom_range(0, 3) == 0) ? $urandom_range(66, 90) : 65);
        end
        3, 4: begin
          code = jhsp_pkg::MARK_SOF0;
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 255) : $urandom_range(1, 4);
          pay = frame_payload(n, (n > 6) ? 6 : n);
        end
        5, 6: begin
          code = jhsp_pkg::MARK_DHT;
          pay = huffman_payload(0, 3, $urandom_range(0, 3));
        end
        7, 8: begin
          case ($urandom_range(0, 2))
            0: code = MARK_APP0;
            1: code = MARK_COM;
            default: code = pick_unknown();
          endcase
          pay = random_bytes($urandom_range(0, 12));
        end
        default: code = jhsp_pkg::MARK_SOI;
      endcase
      if (code == jhsp_pkg::MARK_SOI) begin
        put_marker(jhsp_pkg::MARK_SOI);
      end else begin
        if (pay.size() > 1 && $urandom_range(0, 4) == 0)
          pay = cut_to(pay, $urandom_range(1, pay.size() - 1));
        send_segment(code, pay);
      end
      // Bytes between segments are ignored.
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 254)));
      if (seg_no % 8 == 0) drain_records();
    end

    // The header ends with end of image or a scan header, chosen at random.
    case ($urandom_range(0, 3))
      0: put_marker(jhsp_pkg::MARK_EOI);
      1: send_segment(jhsp_pkg::MARK_SOS, no_bytes);
      2: begin
        n = $urandom_range(0, 6);
        send_segment(jhsp_pkg::MARK_SOS, scan_payload(n, n));
      end
      default: begin
        pay = scan_payload($urandom_range(0, 255), $urandom_range(0, 6));
        send_segment(jhsp_pkg::MARK_SOS, cut_to(pay, $urandom_range(1, pay.size())));
      end
    endcase

    // Everything after completion must be ignored.
    repeat (16) put_byte(8'($urandom_range(0, 255)));
    put_marker(jhsp_pkg::MARK_EOI);
    stream_ch.valid = 1'b0;

    guard = 0;
    while (outstanding != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("tb_jpeg_header_segment_parser: done, clean");
    end else begin
      $display("tb_jpeg_header_segment_parser: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/jhsp_pkg.sv
hdl/jhsp_ifs.sv
hdl/jhsp_in_stage.sv
hdl/jhsp_parser.sv
hdl/jhsp_out_stage.sv
hdl/jpeg_header_segment_parser.sv
sim/jhsp_record_monitor.sv
sim/tb_jpeg_header_segment_parser.sv
